/* sv/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared types, latencies and binary32 helpers for the 4x4 transform unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX = 8'hFF;

  // pipeline depths of the arithmetic units
  localparam int unsigned MulLat  = 5;
  localparam int unsigned AddLat  = 6;
  localparam int unsigned LaneLat = MulLat + 3 * AddLat;

  // register indexes
  typedef enum logic [2:0] {
    REG_ROW0_XY, REG_ROW0_ZW, REG_ROW1_XY, REG_ROW1_ZW,
    REG_ROW2_XY, REG_ROW2_ZW, REG_ROW3_XY, REG_ROW3_ZW
  } reg_idx_e;

  // unrounded value: sig * 2^(ex - 189), or a finished special result
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sgn;
    logic signed [11:0] ex;
    logic [62:0]        sig;
  } nr_in_t;

  function automatic logic fp_is_nan(input logic [31:0] a);
    return a[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] a);
    return a[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic fp_is_zero(input logic [31:0] a);
    return a[30:0] == 31'h0;
  endfunction

  // biased exponent with subnormals taken as exponent one
  function automatic logic [7:0] fp_exp(input logic [31:0] a);
    return (a[30:23] == 8'h00) ? 8'h01 : a[30:23];
  endfunction

  // significand with the hidden bit
  function automatic logic [23:0] fp_mant(input logic [31:0] a);
    return {(a[30:23] != 8'h00), a[22:0]};
  endfunction

endpackage

`default_nettype wire

/* sv/matrix_vector_transform_4x4.sv */
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4
// Vertex transform: 4x4 binary32 matrix held in registers times a vector.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we_i / cfg_addr_i / cfg_wdata_i write one matrix register (two row
//   elements, low word the earlier column); write only while the unit is idle.
//   s_axis carries one vector per item, m_axis one transformed vector per item.
// Pipeline: 24 register stages (multiply 5, three adds of 6 each, output
//   register 1), the first loaded at the accepting edge; tvalid rises
//   as the item enters the output register.
// Throughput: one item per cycle while not stalled; four row lanes run side
//   by side, each a fully pipelined multiply/add chain.
// Stall: the whole pipeline holds while the output register is full and not
//   taken; s_axis_tready drops in the same cycle.
// Reset: matrix registers clear to zero, pipeline and output hold no items.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_vector_transform_4x4 (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [63:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata    // out_x, out_y, out_z, out_w
);
  import mvt_pkg::*;

  logic [63:0]        row_q [8];
  logic [LaneLat-1:0] vld_q;
  logic               en;
  logic               out_vld_q;
  logic [127:0]       out_q;
  logic [31:0]        dot [4];

  // pipeline advances when the output register is free or being drained
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) row_q[i] <= 64'd0;
    end else if (cfg_we_i) begin
      row_q[cfg_addr_i] <= cfg_wdata_i;
    end
  end

  // row lanes
  for (genvar r = 0; r < 4; r++) begin : g_lane
    mvt_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .m_x_i (row_q[2*r][31:0]),
      .m_y_i (row_q[2*r][63:32]),
      .m_z_i (row_q[2*r+1][31:0]),
      .m_w_i (row_q[2*r+1][63:32]),
      .v_x_i (s_axis_tdata[31:0]),
      .v_y_i (s_axis_tdata[63:32]),
      .v_z_i (s_axis_tdata[95:64]),
      .v_w_i (s_axis_tdata[127:96]),
      .dot_o (dot[r])
    );
  end

  // item tracking alongside the lanes and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[LaneLat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[LaneLat-1];
    end
  end

  // merge the lane results into the output item
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {dot[3], dot[2], dot[1], dot[0]};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

/* sv/mvt_norm_round.sv */
// ----------------------------------------------------------------------------
// mvt_norm_round
// Four-stage normalize, denormalize and round-to-nearest-even pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_norm_round (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire mvt_pkg::nr_in_t nr_i,
  output logic [31:0]         res_o
);
  import mvt_pkg::*;

  nr_in_t             s1_q, s2_q, s3_q;
  logic [5:0]         lz_d, lz_q;
  nr_in_t             s2_d, s3_d;
  logic [31:0]        res_d, res_q;
  logic [8:0]         sh;
  logic [62:0]        lost;
  logic [23:0]        mant;
  logic [24:0]        mant_r;
  logic               rup;
  logic signed [11:0] ex4;

  // leading zero count
  always_comb begin
    lz_d = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (nr_i.sig[i]) lz_d = 6'(62 - i);
    end
  end

  // normalize so that bit 62 is set
  always_comb begin
    s2_d     = s1_q;
    s2_d.sig = s1_q.sig << lz_q;
    s2_d.ex  = s1_q.ex - $signed({6'b0, lz_q});
  end

  // shift into the subnormal range with sticky bit
  always_comb begin
    s3_d = s2_q;
    sh   = 9'(12'sd1 - s2_q.ex);
    lost = ~({63{1'b1}} << sh[5:0]) & s2_q.sig;
    if (s2_q.ex < 12'sd1) begin
      if (sh >= 9'd63) begin
        s3_d.sig = 63'd1;
      end else begin
        s3_d.sig = (s2_q.sig >> sh[5:0]) | {62'd0, (lost != 63'd0)};
      end
      s3_d.ex = 12'sd0;
    end
  end

  // round and pack
  always_comb begin
    mant   = s3_q.sig[62:39];
    rup    = s3_q.sig[38] & ((s3_q.sig[37:0] != 38'd0) | mant[0]);
    mant_r = {1'b0, mant} + {24'd0, rup};
    ex4    = s3_q.ex;
    if (s3_q.spec) begin
      res_d = s3_q.spec_val;
    end else if (s3_q.ex == 12'sd0) begin
      res_d = {s3_q.sgn, 31'(mant_r)};
    end else begin
      if (mant_r[24]) begin
        mant_r = mant_r >> 1;
        ex4    = s3_q.ex + 12'sd1;
      end
      if (ex4 >= 12'sd255) begin
        res_d = {s3_q.sgn, EXP_MAX, 23'd0};
      end else begin
        res_d = {s3_q.sgn, ex4[7:0], mant_r[22:0]};
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= nr_i;
      lz_q  <= lz_d;
      s2_q  <= s2_d;
      s3_q  <= s3_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* sv/mvt_fmul.sv */
// ----------------------------------------------------------------------------
// mvt_fmul
// Pipelined binary32 multiplier: special cases and significand product,
// then the shared normalize and round pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_fmul (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      p_o
);
  import mvt_pkg::*;

  nr_in_t      nr_d, nr_q;
  logic        sgn;
  logic [47:0] prod;

  // special cases and product
  always_comb begin
    sgn           = a_i[31] ^ b_i[31];
    prod          = fp_mant(a_i) * fp_mant(b_i);
    nr_d.sgn      = sgn;
    nr_d.ex       = $signed({4'b0, fp_exp(a_i)}) + $signed({4'b0, fp_exp(b_i)})
                    - 12'sd111;
    nr_d.sig      = {15'd0, prod};
    nr_d.spec     = 1'b1;
    nr_d.spec_val = {sgn, 31'd0};
    if (fp_is_nan(a_i) || fp_is_nan(b_i)) begin
      nr_d.spec_val = QNAN;
    end else if (fp_is_inf(a_i) || fp_is_inf(b_i)) begin
      if (fp_is_zero(a_i) || fp_is_zero(b_i)) nr_d.spec_val = QNAN;
      else nr_d.spec_val = {sgn, EXP_MAX, 23'd0};
    end else if (fp_is_zero(a_i) || fp_is_zero(b_i)) begin
      nr_d.spec_val = {sgn, 31'd0};
    end else begin
      nr_d.spec = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) nr_q <= nr_d;
  end

  mvt_norm_round u_round (
    .clk_i (clk_i),
    .en_i  (en_i),
    .nr_i  (nr_q),
    .res_o (p_o)
  );

endmodule

`default_nettype wire

/* sv/mvt_fadd.sv */
// ----------------------------------------------------------------------------
// mvt_fadd
// Pipelined binary32 adder: order operands, align and add, then the shared
// normalize and round pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_fadd (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      s_o
);
  import mvt_pkg::*;

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sa;
    logic        sb;
    logic [7:0]  ea;
    logic [7:0]  d;
    logic [61:0] ma;
    logic [61:0] mb;
  } ord_t;

  ord_t        o_d, o_q;
  nr_in_t      nr_d, nr_q;
  logic [7:0]  ea, eb;
  logic [61:0] ma, mb, mb_al, lost;
  logic [62:0] sum;
  logic        swap;

  // special cases and operand ordering
  always_comb begin
    ea   = fp_exp(a_i);
    eb   = fp_exp(b_i);
    ma   = {fp_mant(a_i), 38'd0};
    mb   = {fp_mant(b_i), 38'd0};
    swap = (eb > ea) || ((eb == ea) && (mb > ma));
    o_d.sa = swap ? b_i[31] : a_i[31];
    o_d.sb = swap ? a_i[31] : b_i[31];
    o_d.ea = swap ? eb : ea;
    o_d.ma = swap ? mb : ma;
    o_d.mb = swap ? ma : mb;
    o_d.d  = swap ? (eb - ea) : (ea - eb);
    o_d.spec     = 1'b1;
    o_d.spec_val = a_i;
    if (fp_is_nan(a_i) || fp_is_nan(b_i)) begin
      o_d.spec_val = QNAN;
    end else if (fp_is_inf(a_i) && fp_is_inf(b_i)) begin
      o_d.spec_val = (a_i[31] == b_i[31]) ? a_i : QNAN;
    end else if (fp_is_inf(a_i)) begin
      o_d.spec_val = a_i;
    end else if (fp_is_inf(b_i)) begin
      o_d.spec_val = b_i;
    end else if (fp_is_zero(a_i) && fp_is_zero(b_i)) begin
      o_d.spec_val = {a_i[31] & b_i[31], 31'd0};
    end else if (fp_is_zero(a_i)) begin
      o_d.spec_val = b_i;
    end else if (fp_is_zero(b_i)) begin
      o_d.spec_val = a_i;
    end else begin
      o_d.spec = 1'b0;
    end
  end

  // alignment and add or subtract
  always_comb begin
    lost = ~({62{1'b1}} << o_q.d[5:0]) & o_q.mb;
    if (o_q.d >= 8'd63) begin
      mb_al = 62'd1;
    end else begin
      mb_al = (o_q.mb >> o_q.d[5:0]) | {61'd0, (lost != 62'd0)};
    end
    if (o_q.sa == o_q.sb) sum = {1'b0, o_q.ma} + {1'b0, mb_al};
    else sum = {1'b0, o_q.ma} - {1'b0, mb_al};
    nr_d.sgn      = o_q.sa;
    nr_d.ex       = $signed({4'b0, o_q.ea}) + 12'sd1;
    nr_d.sig      = sum;
    nr_d.spec     = o_q.spec;
    nr_d.spec_val = o_q.spec_val;
    if (!o_q.spec && sum == 63'd0) begin
      nr_d.spec     = 1'b1;
      nr_d.spec_val = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      o_q  <= o_d;
      nr_q <= nr_d;
    end
  end

  mvt_norm_round u_round (
    .clk_i (clk_i),
    .en_i  (en_i),
    .nr_i  (nr_q),
    .res_o (s_o)
  );

endmodule

`default_nettype wire

/* sv/mvt_lane.sv */
// ----------------------------------------------------------------------------
// mvt_lane
// One matrix row dotted with the vector: four multipliers and a chain of
// three adders, later products delayed to meet the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_lane (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] m_x_i,
  input  wire logic [31:0] m_y_i,
  input  wire logic [31:0] m_z_i,
  input  wire logic [31:0] m_w_i,
  input  wire logic [31:0] v_x_i,
  input  wire logic [31:0] v_y_i,
  input  wire logic [31:0] v_z_i,
  input  wire logic [31:0] v_w_i,
  output logic [31:0]      dot_o
);
  import mvt_pkg::*;

  logic [31:0] p0, p1, p2, p3, s1, s2;
  logic [31:0] p2_dly_q [AddLat];
  logic [31:0] p3_dly_q [2*AddLat];

  mvt_fmul u_mul0 (.clk_i(clk_i), .en_i(en_i), .a_i(m_x_i), .b_i(v_x_i), .p_o(p0));
  mvt_fmul u_mul1 (.clk_i(clk_i), .en_i(en_i), .a_i(m_y_i), .b_i(v_y_i), .p_o(p1));
  mvt_fmul u_mul2 (.clk_i(clk_i), .en_i(en_i), .a_i(m_z_i), .b_i(v_z_i), .p_o(p2));
  mvt_fmul u_mul3 (.clk_i(clk_i), .en_i(en_i), .a_i(m_w_i), .b_i(v_w_i), .p_o(p3));

  // delay lines for the later products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_dly_q[0] <= p2;
      for (int i = 1; i < AddLat; i++) p2_dly_q[i] <= p2_dly_q[i-1];
      p3_dly_q[0] <= p3;
      for (int i = 1; i < 2*AddLat; i++) p3_dly_q[i] <= p3_dly_q[i-1];
    end
  end

  mvt_fadd u_add0 (.clk_i(clk_i), .en_i(en_i), .a_i(p0), .b_i(p1), .s_o(s1));
  mvt_fadd u_add1 (.clk_i(clk_i), .en_i(en_i), .a_i(s1),
                   .b_i(p2_dly_q[AddLat-1]), .s_o(s2));
  mvt_fadd u_add2 (.clk_i(clk_i), .en_i(en_i), .a_i(s2),
                   .b_i(p3_dly_q[2*AddLat-1]), .s_o(dot_o));

endmodule

`default_nettype wire
